FILE: hdl/nslp_pkg.sv
// ----------------------------------------------------------------------------
// nslp_pkg
// Shared types and constants for nearest seed label propagation.
// ----------------------------------------------------------------------------
package nslp_pkg;

  localparam int CFG_W = 11;
  localparam int PIX_W = 8;
  localparam logic [CFG_W-1:0] WIDTH_RESET = 11'd640;

  typedef struct packed {
    logic seed;
    logic border;
  } pix_ctl_t;

endpackage

FILE: hdl/nslp_ram.sv
// ----------------------------------------------------------------------------
// nslp_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module nslp_ram #(
  parameter int DATA_W = 20,
  parameter int DEPTH  = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/nslp_sel.sv
// ----------------------------------------------------------------------------
// nslp_sel
// Neighbor select: pick the nearer known neighbor, increment its distance.
// ----------------------------------------------------------------------------
module nslp_sel
  import nslp_pkg::*;
#(
  parameter int DIST_BITS = 11
) (
  input  pix_ctl_t             ctl,
  input  logic [PIX_W-1:0]     cost,
  input  logic                 up_known,
  input  logic [DIST_BITS-1:0] up_dist,
  input  logic [PIX_W-1:0]     up_label,
  input  logic                 lf_known,
  input  logic [DIST_BITS-1:0] lf_dist,
  input  logic [PIX_W-1:0]     lf_label,
  output logic [PIX_W-1:0]     label,
  output logic [DIST_BITS-1:0] distance,
  output logic                 known,
  output logic                 err
);

  localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

  logic                 take_up;
  logic [DIST_BITS-1:0] src_dist;
  logic [PIX_W-1:0]     src_label;

  assign take_up   = up_known && (!lf_known || (up_dist < lf_dist));
  assign src_dist  = take_up ? up_dist : lf_dist;
  assign src_label = take_up ? up_label : lf_label;

  always_comb begin
    label    = cost;
    distance = '0;
    known    = 1'b0;
    err      = 1'b0;
    if (ctl.seed) begin
      known = 1'b1;
    end else if (!ctl.border && (up_known || lf_known)) begin
      known    = 1'b1;
      label    = src_label;
      distance = (src_dist == DIST_MAX) ? DIST_MAX : src_dist + DIST_BITS'(1);
      err      = (src_label == '0);
    end
  end

endmodule

FILE: hdl/nearest_seed_label_propagation.sv
// ----------------------------------------------------------------------------
// nearest_seed_label_propagation
// Forward city-block distance pass with label copy over a raster stream.
// ----------------------------------------------------------------------------
// Flow: an accepted transaction is registered into stage one while the line store
//   is read, then selected, written back and registered into the output stage.
// Throughput: one pixel per cycle while out_stall is low, bounded by the single line store port pair.
// Reset: clears row/column tracking, left neighbor, stage-one and output valid and
//   loads the reset width; the line store is not cleared and needs no clearing pass.
module nearest_seed_label_propagation
  import nslp_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  parameter int DIST_BITS = 11
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_write_en,
  input  logic [CFG_W-1:0]     cfg_write_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PIX_W-1:0]     in_cost,
  input  logic [PIX_W-1:0]     in_intensity,
  input  logic                 in_frame_start,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [PIX_W-1:0]     out_label,
  output logic [DIST_BITS-1:0] out_distance,
  output logic                 out_known,
  output logic                 out_zero_source_error
);

  localparam int COL_BITS = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int CMP_W    = (COL_BITS + 1 > CFG_W) ? COL_BITS + 1 : CFG_W;
  localparam int ENT_W    = 1 + DIST_BITS + PIX_W;

  logic [CFG_W-1:0]     width_cfg_r;
  logic [COL_BITS-1:0]  col_cnt_r, col_cnt_nxt;
  logic                 first_row_r, first_row_nxt;

  logic                 s1_v_r, s1_v_nxt;
  pix_ctl_t             s1_ctl_r;
  logic [PIX_W-1:0]     s1_cost_r;
  logic [COL_BITS-1:0]  s1_col_r;

  logic                 lf_known_r;
  logic [DIST_BITS-1:0] lf_dist_r;
  logic [PIX_W-1:0]     lf_label_r;

  logic                 out_v_r, out_v_nxt;
  logic [PIX_W-1:0]     out_label_r;
  logic [DIST_BITS-1:0] out_dist_r;
  logic                 out_known_r;
  logic                 out_err_r;

  logic                 in_acc;
  logic                 s1_fire;
  logic [CMP_W-1:0]     width_ext;
  logic [CMP_W-1:0]     width_eff;
  logic [COL_BITS-1:0]  col_cur;
  logic                 frow_cur;
  logic [CMP_W-1:0]     col_inc;
  pix_ctl_t             ctl_cur;

  logic [ENT_W-1:0]     up_ent;
  logic [ENT_W-1:0]     wr_ent;
  logic                 up_known;
  logic [DIST_BITS-1:0] up_dist;
  logic [PIX_W-1:0]     up_label;

  logic [PIX_W-1:0]     sel_label;
  logic [DIST_BITS-1:0] sel_dist;
  logic                 sel_known;
  logic                 sel_err;

  // handshake
  assign s1_fire  = s1_v_r && (!out_v_r || !out_stall);
  assign in_stall = s1_v_r && !s1_fire;
  assign in_acc   = in_valid && !in_stall;

  // row and column tracking
  assign width_ext = CMP_W'(width_cfg_r);
  assign width_eff = (width_ext < CMP_W'(2)) ? CMP_W'(2) :
                     (width_ext > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH) : width_ext;
  assign col_cur   = in_frame_start ? '0 : col_cnt_r;
  assign frow_cur  = in_frame_start || first_row_r;
  assign col_inc   = CMP_W'(col_cur) + CMP_W'(1);

  assign ctl_cur.seed   = (in_intensity != '0);
  assign ctl_cur.border = frow_cur || (col_cur == '0);

  always_comb begin
    col_cnt_nxt   = col_cnt_r;
    first_row_nxt = first_row_r;
    if (in_acc) begin
      if (col_inc >= width_eff) begin
        col_cnt_nxt   = '0;
        first_row_nxt = 1'b0;
      end else begin
        col_cnt_nxt   = col_inc[COL_BITS-1:0];
        first_row_nxt = frow_cur;
      end
    end
  end

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_acc) begin
      s1_v_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (s1_fire) begin
      out_v_nxt = 1'b1;
    end else if (!out_stall) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_cfg_r <= WIDTH_RESET;
      col_cnt_r   <= '0;
      first_row_r <= 1'b1;
      s1_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
      lf_known_r  <= 1'b0;
      lf_dist_r   <= '0;
      lf_label_r  <= '0;
    end else begin
      if (cfg_write_en) begin
        width_cfg_r <= cfg_write_data;
      end
      col_cnt_r   <= col_cnt_nxt;
      first_row_r <= first_row_nxt;
      s1_v_r      <= s1_v_nxt;
      out_v_r     <= out_v_nxt;
      if (s1_fire) begin
        lf_known_r <= sel_known;
        lf_dist_r  <= sel_dist;
        lf_label_r <= sel_label;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ctl_r  <= ctl_cur;
      s1_cost_r <= in_cost;
      s1_col_r  <= col_cur;
    end
    if (s1_fire) begin
      out_label_r <= sel_label;
      out_dist_r  <= sel_dist;
      out_known_r <= sel_known;
      out_err_r   <= sel_err;
    end
  end

  // line store of the previous output row
  assign wr_ent = {sel_known, sel_dist, sel_label};

  nslp_ram #(
    .DATA_W (ENT_W),
    .DEPTH  (MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_col_r),
    .wdata (wr_ent),
    .re    (in_acc),
    .raddr (col_cur),
    .rdata (up_ent)
  );

  assign up_known = up_ent[ENT_W-1];
  assign up_dist  = up_ent[PIX_W +: DIST_BITS];
  assign up_label = up_ent[PIX_W-1:0];

  nslp_sel #(
    .DIST_BITS (DIST_BITS)
  ) u_sel (
    .ctl      (s1_ctl_r),
    .cost     (s1_cost_r),
    .up_known (up_known),
    .up_dist  (up_dist),
    .up_label (up_label),
    .lf_known (lf_known_r),
    .lf_dist  (lf_dist_r),
    .lf_label (lf_label_r),
    .label    (sel_label),
    .distance (sel_dist),
    .known    (sel_known),
    .err      (sel_err)
  );

  assign out_valid             = out_v_r;
  assign out_label             = out_label_r;
  assign out_distance          = out_dist_r;
  assign out_known             = out_known_r;
  assign out_zero_source_error = out_err_r;

`ifndef NO_ASSERTIONS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_v_r && out_v_r))
    else $error("input stalled with a free stage");

  a_frame_start_col: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_frame_start) |=> (col_cnt_r == COL_BITS'(1) && first_row_r))
    else $error("frame start did not restart row tracking");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && out_v_r && out_stall) |=> s1_v_r)
    else $error("stage one dropped a pending transaction");

  a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_known_r) |-> (out_dist_r == '0 && !out_err_r))
    else $error("unknown result carries distance or error");
`endif

endmodule

FILE: sim/nslp_distance_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nslp_distance_checker
// Watches the pixel and result channels and the width register port. Keeps
// its own line store and left neighbor to predict label, distance, known and
// zero-source flag per pixel. Compares each result transaction in order and
// counts mismatches for the testbench top.
// ----------------------------------------------------------------------------
module nslp_distance_checker
  import nslp_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  parameter int DIST_BITS = 11
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_write_en,
  input  logic [CFG_W-1:0]     cfg_write_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [PIX_W-1:0]     in_cost,
  input  logic [PIX_W-1:0]     in_intensity,
  input  logic                 in_frame_start,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [PIX_W-1:0]     out_label,
  input  logic [DIST_BITS-1:0] out_distance,
  input  logic                 out_known,
  input  logic                 out_zero_source_error,
  output int                   fail_count,
  output int                   pending
);

  localparam logic [DIST_BITS:0] NO_DIST  = '1;
  localparam logic [DIST_BITS:0] DIST_SAT = {1'b0, {DIST_BITS{1'b1}}};

  typedef struct packed {
    logic [PIX_W-1:0]     label;
    logic [DIST_BITS-1:0] distance;
    logic                 known;
    logic                 zero_source_error;
  } pixel_result_t;

  logic [DIST_BITS:0] above_dist [MAX_WIDTH];
  logic [PIX_W-1:0]   above_label [MAX_WIDTH];
  logic [DIST_BITS:0] left_dist;
  logic [PIX_W-1:0]   left_label;
  int unsigned        col_count;
  logic               top_row;
  logic [CFG_W-1:0]   width_reg;

  pixel_result_t expected_pixels [$];

  function automatic logic [DIST_BITS:0] step_dist(input logic [DIST_BITS:0] d);
    return (d >= DIST_SAT) ? DIST_SAT : d + 1'b1;
  endfunction

  function automatic pixel_result_t propagate_pixel(input logic [PIX_W-1:0] cost,
                                                    input logic [PIX_W-1:0] intensity,
                                                    input logic frame_start);
    int unsigned        w;
    int unsigned        c;
    logic [DIST_BITS:0] d;
    logic [DIST_BITS:0] up;
    logic [PIX_W-1:0]   lbl;
    logic               err;
    pixel_result_t      r;
    w = width_reg;
    if (w < 2) w = 2;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (frame_start) begin
      col_count = 0;
      top_row = 1'b1;
    end
    c = col_count;
    if (c >= MAX_WIDTH) c = 0;
    err = 1'b0;
    if (intensity != '0) begin
      lbl = cost;
      d = '0;
    end else if (top_row || c == 0) begin
      lbl = cost;
      d = NO_DIST;
    end else begin
      up = above_dist[c];
      if (up == NO_DIST && left_dist == NO_DIST) begin
        lbl = cost;
        d = NO_DIST;
      end else if (up < left_dist) begin
        d = step_dist(up);
        lbl = above_label[c];
        err = (lbl == '0);
      end else begin
        d = step_dist(left_dist);
        lbl = left_label;
        err = (lbl == '0);
      end
    end
    above_dist[c] = d;
    above_label[c] = lbl;
    left_dist = d;
    left_label = lbl;
    if (c + 1 >= w) begin
      col_count = 0;
      top_row = 1'b0;
    end else begin
      col_count = c + 1;
    end
    r.label = lbl;
    r.known = (d != NO_DIST);
    r.distance = r.known ? d[DIST_BITS-1:0] : '0;
    r.zero_source_error = err;
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    pixel_result_t want;
    if (!rst_n) begin
      width_reg = WIDTH_RESET;
      left_dist = NO_DIST;
      left_label = '0;
      col_count = 0;
      top_row = 1'b1;
      fail_count = 0;
      expected_pixels.delete();
    end else begin
      if (cfg_write_en) width_reg = cfg_write_data;
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          $error("result transaction with nothing expected: label %0d distance %0d",
                 out_label, out_distance);
          fail_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (out_label !== want.label) begin
            $error("label mismatch: expected %0d, actual %0d", want.label, out_label);
            fail_count++;
          end
          if (out_distance !== want.distance) begin
            $error("distance mismatch: expected %0d, actual %0d", want.distance, out_distance);
            fail_count++;
          end
          if (out_known !== want.known) begin
            $error("known mismatch: expected %0d, actual %0d", want.known, out_known);
            fail_count++;
          end
          if (out_zero_source_error !== want.zero_source_error) begin
            $error("zero_source_error mismatch: expected %0d, actual %0d",
                   want.zero_source_error, out_zero_source_error);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        expected_pixels.push_back(propagate_pixel(in_cost, in_intensity, in_frame_start));
    end
    pending <= expected_pixels.size();
  end

endmodule

FILE: sim/nearest_seed_label_propagation_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_seed_label_propagation_tb
// Drives raster pixel streams into the distance pass: a short directed run
// over borders, seeds, ties and zero labels, a long two-column frame that
// carries the distance down many rows, then random frames over a range of
// row widths. Both channels idle at random; the result side holds off once
// for a long stretch. A checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module nearest_seed_label_propagation_tb;
  import nslp_pkg::*;

  localparam int MAX_WIDTH = 1024;
  localparam int DIST_BITS = 11;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_write_en;
  logic [CFG_W-1:0]     cfg_write_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [PIX_W-1:0]     in_cost;
  logic [PIX_W-1:0]     in_intensity;
  logic                 in_frame_start;
  logic                 out_valid;
  logic                 out_stall;
  logic [PIX_W-1:0]     out_label;
  logic [DIST_BITS-1:0] out_distance;
  logic                 out_known;
  logic                 out_zero_source_error;

  int          fail_count;
  int          pending;
  bit          quiet;
  int unsigned cur_width;

  nearest_seed_label_propagation #(
    .MAX_WIDTH(MAX_WIDTH),
    .DIST_BITS(DIST_BITS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_write_en(cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_cost(in_cost),
    .in_intensity(in_intensity),
    .in_frame_start(in_frame_start),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_label(out_label),
    .out_distance(out_distance),
    .out_known(out_known),
    .out_zero_source_error(out_zero_source_error)
  );

  nslp_distance_checker #(
    .MAX_WIDTH(MAX_WIDTH),
    .DIST_BITS(DIST_BITS)
  ) checker_i (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_write_en(cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_cost(in_cost),
    .in_intensity(in_intensity),
    .in_frame_start(in_frame_start),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_label(out_label),
    .out_distance(out_distance),
    .out_known(out_known),
    .out_zero_source_error(out_zero_source_error),
    .fail_count(fail_count),
    .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("nearest_seed_label_propagation_tb NOT OK");
    $finish;
  end

  initial begin : result_sink
    int unsigned gap;
    int unsigned taken;
    taken = 0;
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken == 300) gap = 64;
      else if (quiet) gap = 0;
      else gap = $urandom_range(0, 3);
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  task automatic send_pixel(input logic [PIX_W-1:0] cost, input logic [PIX_W-1:0] intensity,
                            input logic fs);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cost <= cost;
    in_intensity <= intensity;
    in_frame_start <= fs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_width(input logic [CFG_W-1:0] value);
    drain();
    cfg_write_en <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  // restart the frame whenever the row grows, so no unwritten line store entry is read
  task automatic random_phase(input logic [CFG_W-1:0] width_val, input int unsigned n_items,
                              input int unsigned seed_odds, input bit noisy);
    int unsigned      eff;
    int unsigned      frame_left;
    logic [PIX_W-1:0] cost;
    logic [PIX_W-1:0] intensity;
    logic             fs;
    eff = (width_val < 2) ? 2 : (width_val > MAX_WIDTH) ? MAX_WIDTH : width_val;
    frame_left = (eff > cur_width || $urandom_range(0, 1) == 1) ? 0 : eff * 3;
    write_width(width_val);
    cur_width = eff;
    for (int unsigned i = 0; i < n_items; i++) begin
      fs = 1'b0;
      if (frame_left == 0) begin
        fs = 1'b1;
        frame_left = eff * $urandom_range(2, 6);
      end else if (noisy && $urandom_range(0, 299) == 0) begin
        fs = 1'b1;
      end
      frame_left--;
      cost = ($urandom_range(0, 7) == 0) ? '0 : PIX_W'($urandom_range(0, 255));
      intensity = ($urandom_range(1, seed_odds) == 1) ? PIX_W'($urandom_range(1, 255)) : '0;
      send_pixel(cost, intensity, fs);
    end
  endtask

  initial begin : stimulus
    quiet = 1'b0;
    cur_width = WIDTH_RESET;
    rst_n <= 1'b0;
    cfg_write_en <= 1'b0;
    cfg_write_data <= '0;
    in_valid <= 1'b0;
    in_cost <= '0;
    in_intensity <= '0;
    in_frame_start <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // first row at the reset width, no frame start
    send_pixel(8'd0, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd255, 1'b0);
    send_pixel(8'd0, 8'd1, 1'b0);
    send_pixel(8'd255, 8'd128, 1'b0);
    // narrow below the minimum in mid-row; the next pixel closes the row
    write_width(11'd0);
    cur_width = 2;
    send_pixel(8'd17, 8'd0, 1'b0);
    send_pixel(8'd33, 8'd0, 1'b0);
    send_pixel(8'd44, 8'd0, 1'b0);
    send_pixel(8'd5, 8'd0, 1'b0);
    send_pixel(8'd6, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd7, 1'b0);
    send_pixel(8'd9, 8'd0, 1'b0);
    send_pixel(8'd3, 8'd0, 1'b0);
    send_pixel(8'd200, 8'd64, 1'b0);
    send_pixel(8'd0, 8'd0, 1'b0);
    send_pixel(8'd90, 8'd32, 1'b0);
    send_pixel(8'd60, 8'd8, 1'b0);
    send_pixel(8'd0, 8'd0, 1'b0);
    send_pixel(8'd11, 8'd0, 1'b1);
    send_pixel(8'd12, 8'd0, 1'b0);
    send_pixel(8'd13, 8'd0, 1'b0);
    send_pixel(8'd14, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd16, 1'b1);
    send_pixel(8'd255, 8'd2, 1'b0);

    // two-column frame, one seed: distance climbs one per row
    write_width(11'd2);
    for (int r = 0; r < 200; r++) begin
      send_pixel(PIX_W'($urandom_range(0, 255)), 8'd0, r == 0);
      send_pixel(PIX_W'($urandom_range(0, 255)),
                 (r == 1) ? PIX_W'($urandom_range(1, 255)) : 8'd0, 1'b0);
    end

    quiet = 1'b1;
    random_phase(11'd1, 100, 4, 1'b1);
    quiet = 1'b0;
    random_phase(11'd3, 100, 8, 1'b1);
    random_phase(11'd16, 120, 16, 1'b1);
    random_phase(11'd5, 100, 6, 1'b1);
    quiet = 1'b1;
    random_phase(11'd33, 100, 20, 1'b1);
    quiet = 1'b0;
    random_phase(11'd100, 150, 40, 1'b1);
    random_phase(11'd2047, 300, 300, 1'b0);
    random_phase(11'd1025, 100, 30, 1'b1);
    random_phase(11'd640, 100, 30, 1'b1);
    random_phase(11'd1024, 80, 30, 1'b1);
    random_phase(11'd7, 100, 5, 1'b1);

    drain();
    if (fail_count == 0) begin
      $display("nearest_seed_label_propagation_tb OK");
    end else begin
      $display("nearest_seed_label_propagation_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/nslp_pkg.sv
hdl/nslp_ram.sv
hdl/nslp_sel.sv
hdl/nearest_seed_label_propagation.sv
sim/nslp_distance_checker.sv
sim/nearest_seed_label_propagation_tb.sv
